@@ hw/rtl/tkmh_pkg.sv @@
// Package with the transaction types, microcode encoding and program of the top-K heap selector.
package tkmh_pkg;

    localparam int HEAP_SIZE_DEF = 128;

    typedef struct packed {
        logic        opcode;
        logic [31:0] score;
        logic [15:0] cand_id;
        logic [6:0]  position;
    } t_in;

    typedef struct packed {
        logic [31:0] out_score;
        logic [15:0] out_id;
        logic [38:0] kept_sum;
    } t_out;

    typedef struct packed {
        logic [31:0] score;
        logic [15:0] id;
    } t_entry;

    localparam logic OPC_OFFER = 1'b0;
    localparam logic OPC_READ  = 1'b1;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_RD_OUT   = 4'd3;
    localparam logic [3:0] S_CHECK    = 4'd4;
    localparam logic [3:0] S_ROOT_OUT = 4'd5;
    localparam logic [3:0] S_SUM      = 4'd6;
    localparam logic [3:0] S_KIDS     = 4'd7;
    localparam logic [3:0] S_CMP      = 4'd8;
    localparam logic [3:0] S_MOVE     = 4'd9;
    localparam logic [3:0] S_PLACE    = 4'd10;
    localparam logic [3:0] S_RDROOT   = 4'd11;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CLEAR    = 4'd1;
    localparam logic [3:0] OP_ACCEPT   = 4'd2;
    localparam logic [3:0] OP_SUM      = 4'd3;
    localparam logic [3:0] OP_KIDS     = 4'd4;
    localparam logic [3:0] OP_MOVE     = 4'd5;
    localparam logic [3:0] OP_PLACE    = 4'd6;
    localparam logic [3:0] OP_RDROOT   = 4'd7;
    localparam logic [3:0] OP_OUT_RD   = 4'd8;
    localparam logic [3:0] OP_OUT_ROOT = 4'd9;

    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_CLR_LAST = 3'd1;
    localparam logic [2:0] C_IN_ACC   = 3'd2;
    localparam logic [2:0] C_IS_READ  = 3'd3;
    localparam logic [2:0] C_WIN      = 3'd4;
    localparam logic [2:0] C_NO_CHILD = 3'd5;
    localparam logic [2:0] C_ITEM_GT  = 3'd6;
    localparam logic [2:0] C_OUT_FREE = 3'd7;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [3:0] jt;
        logic [3:0] jf;
    } t_uword;

    function automatic t_uword ucode(input logic [3:0] step);
        t_uword w;
        case (step)
            S_CLEAR:    w = '{OP_CLEAR,    C_CLR_LAST, S_IDLE,     S_CLEAR};
            S_IDLE:     w = '{OP_ACCEPT,   C_IN_ACC,   S_DISP,     S_IDLE};
            S_DISP:     w = '{OP_NONE,     C_IS_READ,  S_RD_OUT,   S_CHECK};
            S_RD_OUT:   w = '{OP_OUT_RD,   C_OUT_FREE, S_IDLE,     S_RD_OUT};
            S_CHECK:    w = '{OP_NONE,     C_WIN,      S_SUM,      S_ROOT_OUT};
            S_ROOT_OUT: w = '{OP_OUT_ROOT, C_OUT_FREE, S_IDLE,     S_ROOT_OUT};
            S_SUM:      w = '{OP_SUM,      C_ALWAYS,   S_KIDS,     S_KIDS};
            S_KIDS:     w = '{OP_KIDS,     C_NO_CHILD, S_PLACE,    S_CMP};
            S_CMP:      w = '{OP_NONE,     C_ITEM_GT,  S_MOVE,     S_PLACE};
            S_MOVE:     w = '{OP_MOVE,     C_ALWAYS,   S_KIDS,     S_KIDS};
            S_PLACE:    w = '{OP_PLACE,    C_ALWAYS,   S_RDROOT,   S_RDROOT};
            S_RDROOT:   w = '{OP_RDROOT,   C_ALWAYS,   S_ROOT_OUT, S_ROOT_OUT};
            default:    w = '{OP_NONE,     C_ALWAYS,   S_IDLE,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/top_k_min_heap_selector.sv @@
// Top-K selector: microcoded min-heap sequencer that keeps the largest scores of a stream.
//
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_data  (opcode, score, cand_id, position)
// out       output     o_out_valid / i_out_ready  o_out_data (out_score, out_id, kept_sum)
//
// After reset a clearing pass writes zero to every heap entry. A read steps through the
// accept, dispatch and output states, and an offer that does not beat the root through
// accept, dispatch, check and root output. An offer that replaces the root updates the
// sum, then sinks the new entry level by level, at most log2(HEAP_SIZE) levels, places it,
// rereads the root and outputs it; each level is a child read, a compare
// and a write on the heap memory. The result sits in an output register, so a stalled
// output only holds the sequencer when the next result is ready to be loaded.
module top_k_min_heap_selector #(
    parameter int HEAP_SIZE = tkmh_pkg::HEAP_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tkmh_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tkmh_pkg::t_out o_out_data
);
    import tkmh_pkg::*;

    localparam int AW = (HEAP_SIZE > 1) ? $clog2(HEAP_SIZE) : 1;
    localparam int KW = AW + 2;
    localparam int CW = ((AW > 7) ? AW : 7) + 1;

    t_entry       mem [HEAP_SIZE];
    t_entry       r_rda;
    t_entry       r_rdb;

    logic [3:0]   r_upc;
    logic [3:0]   n_upc;
    t_uword       uw;
    logic         cond_ok;

    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_node;
    t_entry        r_item;
    logic          r_is_read;
    logic          r_rd_ok;
    logic [38:0]   r_sum;
    t_out          r_out;
    logic          r_out_valid;

    logic          in_acc;
    logic          out_free;
    logic          clr_last;
    logic [CW-1:0] pos_ext;
    logic          pos_ok;
    logic [KW-1:0] lkid;
    logic [KW-1:0] rkid;
    logic          no_child;
    logic          has_right;
    logic          pick_right;
    t_entry        pick;
    logic [AW-1:0] pick_addr;

    logic          we;
    logic [AW-1:0] wa;
    t_entry        wd;
    logic          rea;
    logic [AW-1:0] aa;
    logic          reb;
    logic [AW-1:0] ab;
    logic          out_load;

    assign uw          = ucode(r_upc);
    assign o_in_ready  = (r_upc == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign clr_last  = (r_clr_addr == AW'(HEAP_SIZE - 1));
    assign pos_ext   = CW'(i_in_data.position);
    assign pos_ok    = (pos_ext < CW'(HEAP_SIZE));
    assign lkid      = {1'b0, r_node, 1'b1};
    assign rkid      = lkid + KW'(1);
    assign no_child  = (lkid >= KW'(HEAP_SIZE));
    assign has_right = (rkid < KW'(HEAP_SIZE));

    always_comb begin
        pick_right = has_right && !(r_rda.score < r_rdb.score);
        pick       = pick_right ? r_rdb : r_rda;
        pick_addr  = pick_right ? rkid[AW-1:0] : lkid[AW-1:0];
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_CLR_LAST: cond_ok = clr_last;
            C_IN_ACC:   cond_ok = in_acc;
            C_IS_READ:  cond_ok = r_is_read;
            C_WIN:      cond_ok = (r_item.score > r_rda.score);
            C_NO_CHILD: cond_ok = no_child;
            C_ITEM_GT:  cond_ok = (r_item.score > pick.score);
            C_OUT_FREE: cond_ok = out_free;
            default:    cond_ok = 1'b1;
        endcase
        n_upc = cond_ok ? uw.jt : uw.jf;
    end

    always_comb begin
        we       = 1'b0;
        wa       = r_node;
        wd       = r_item;
        rea      = 1'b0;
        aa       = '0;
        reb      = 1'b0;
        ab       = rkid[AW-1:0];
        out_load = 1'b0;
        case (uw.op)
            OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr_addr;
                wd = '0;
            end
            OP_ACCEPT: begin
                rea = in_acc;
                aa  = (i_in_data.opcode == OPC_READ) ? AW'(pos_ext) : '0;
            end
            OP_KIDS: begin
                rea = !no_child;
                aa  = lkid[AW-1:0];
                reb = has_right;
            end
            OP_MOVE: begin
                we = 1'b1;
                wd = pick;
            end
            OP_PLACE: begin
                we = 1'b1;
            end
            OP_RDROOT: begin
                rea = 1'b1;
            end
            OP_OUT_RD, OP_OUT_ROOT: begin
                out_load = out_free;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rea) begin
            r_rda <= mem[aa];
        end
        if (reb) begin
            r_rdb <= mem[ab];
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == OP_ACCEPT && in_acc) begin
            r_item.score <= i_in_data.score;
            r_item.id    <= i_in_data.cand_id;
            r_is_read    <= (i_in_data.opcode == OPC_READ);
            r_rd_ok      <= pos_ok;
        end
        if (uw.op == OP_SUM) begin
            r_node <= '0;
        end else if (uw.op == OP_MOVE) begin
            r_node <= pick_addr;
        end
        if (out_load) begin
            r_out.out_score <= (uw.op == OP_OUT_RD && !r_rd_ok) ? '0 : r_rda.score;
            r_out.out_id    <= (uw.op == OP_OUT_RD && !r_rd_ok) ? '0 : r_rda.id;
            r_out.kept_sum  <= r_sum;
        end
        if (!i_rst_n) begin
            r_upc       <= S_CLEAR;
            r_clr_addr  <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (uw.op == OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (uw.op == OP_SUM) begin
                r_sum <= r_sum - 39'(r_rda.score) + 39'(r_item.score);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the top-K min-heap selector, checking every result against a heap predictor.
module tb_top;
    import tkmh_pkg::*;

    localparam int HEAP = HEAP_SIZE_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS = 780;

    typedef struct packed {
        t_in        data;
        logic [1:0] gap_after;
        logic       drain;
    } t_stim;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    t_stim stim_q[$];
    t_out  want_q[$];

    t_entry      kept [1:HEAP];
    logic [38:0] kept_total;

    int faults = 0;
    int cycles = 0;
    int gap_left = 0;
    int sink_hold = 0;

    top_k_min_heap_selector #(.HEAP_SIZE(HEAP)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one transaction to the kept heap and returns the result it must produce.
    function automatic t_out heap_apply(input t_in item);
        t_out   res;
        t_entry tmp;
        int     node;
        int     kid;
        int     slot;
        bit     settled;
        res = '0;
        if (item.opcode == OPC_OFFER) begin
            if (item.score > kept[1].score) begin
                kept_total = kept_total - {7'd0, kept[1].score} + {7'd0, item.score};
                kept[1] = {item.score, item.cand_id};
                node = 1;
                settled = 1'b0;
                while (!settled && 2 * node <= HEAP) begin
                    kid = 2 * node;
                    if (kid + 1 <= HEAP && kept[kid].score >= kept[kid + 1].score) begin
                        kid = kid + 1;
                    end
                    if (kept[node].score > kept[kid].score) begin
                        tmp = kept[node];
                        kept[node] = kept[kid];
                        kept[kid] = tmp;
                        node = kid;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
            res.out_score = kept[1].score;
            res.out_id = kept[1].id;
        end else begin
            slot = int'(item.position) + 1;
            if (slot <= HEAP) begin
                res.out_score = kept[slot].score;
                res.out_id = kept[slot].id;
            end
        end
        res.kept_sum = kept_total;
        return res;
    endfunction

    task automatic note_fault(input string what, input logic [63:0] want, input logic [63:0] got);
        faults++;
        if (faults <= 10) begin
            $display("mismatch %0d at cycle %0d: %s expected %0h got %0h",
                     faults, cycles, what, want, got);
        end
    endtask

    task automatic add_item(input logic op, input logic [31:0] sc, input logic [15:0] id,
                            input logic [6:0] pos, input logic [1:0] gap, input logic drain);
        t_stim s;
        s.data.opcode = op;
        s.data.score = sc;
        s.data.cand_id = id;
        s.data.position = pos;
        s.gap_after = gap;
        s.drain = drain;
        stim_q.push_back(s);
    endtask

    always @(posedge i_clk) begin : driver
        bit    accepted;
        t_stim head;
        accepted = in_valid && in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (accepted) begin
                want_q.push_back(heap_apply(in_data));
            end
            if (in_valid && !accepted) begin
                in_valid <= 1'b1;
            end else if (stim_q.size() == 0) begin
                in_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (stim_q[0].drain && want_q.size() != 0) begin
                in_valid <= 1'b0;
            end else begin
                head = stim_q.pop_front();
                in_data <= head.data;
                in_valid <= 1'b1;
                gap_left = int'(head.gap_after);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out want;
        bit   calm;
        calm = ((cycles / 1500) % 4) == 1;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (want_q.size() == 0) begin
                    note_fault("unexpected result, out_score", '0, out_data.out_score);
                end else begin
                    want = want_q.pop_front();
                    if (out_data.out_score !== want.out_score)
                        note_fault("out_score", want.out_score, out_data.out_score);
                    if (out_data.out_id !== want.out_id)
                        note_fault("out_id", want.out_id, out_data.out_id);
                    if (out_data.kept_sum !== want.kept_sum)
                        note_fault("kept_sum", want.kept_sum, out_data.kept_sum);
                end
                sink_hold = calm ? 0 : $urandom_range(0, 3);
            end else if (sink_hold > 0) begin
                sink_hold = sink_hold - 1;
            end
            out_ready <= (sink_hold == 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        int          r;
        logic [31:0] sc;
        logic [31:0] base;
        logic [1:0]  gap;
        bit          calm;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        for (int k = 1; k <= HEAP; k++) begin
            kept[k] = '0;
        end
        kept_total = '0;

        add_item(OPC_READ,  32'h0,        16'h0,    7'h00, 2'd0, 1'b0);
        add_item(OPC_READ,  32'hFFFFFFFF, 16'hFFFF, 7'h7F, 2'd1, 1'b0);
        add_item(OPC_OFFER, 32'h0,        16'hFFFF, 7'h7F, 2'd0, 1'b0);
        add_item(OPC_OFFER, 32'hFFFFFFFF, 16'hFFFF, 7'h7F, 2'd0, 1'b0);
        add_item(OPC_OFFER, 32'h80000000, 16'h8000, 7'h40, 2'd3, 1'b0);
        add_item(OPC_OFFER, 32'h1,        16'h0001, 7'h01, 2'd0, 1'b0);
        add_item(OPC_OFFER, 32'h1,        16'h0002, 7'h02, 2'd2, 1'b0);
        add_item(OPC_READ,  32'h0,        16'h0,    7'h7E, 2'd0, 1'b0);
        add_item(OPC_READ,  32'h0,        16'h0,    7'h7F, 2'd0, 1'b0);
        add_item(OPC_READ,  32'h0,        16'h0,    7'h01, 2'd1, 1'b0);
        add_item(OPC_READ,  32'h0,        16'h0,    7'h02, 2'd0, 1'b1);
        add_item(OPC_OFFER, 32'h0,        16'h1234, 7'h00, 2'd0, 1'b0);
        add_item(OPC_READ,  32'h0,        16'h0,    7'h3F, 2'd0, 1'b0);
        add_item(OPC_OFFER, 32'h5,        16'h5555, 7'h55, 2'd1, 1'b0);
        add_item(OPC_OFFER, 32'h5,        16'hAAAA, 7'h2A, 2'd0, 1'b0);
        add_item(OPC_READ,  32'h0,        16'h0,    7'h40, 2'd3, 1'b0);
        add_item(OPC_OFFER, 32'h7FFFFFFF, 16'h7FFF, 7'h00, 2'd0, 1'b1);
        add_item(OPC_READ,  32'h0,        16'h0,    7'h00, 2'd0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = ((i / 64) % 4) == 3;
            gap = calm ? 2'd0 : 2'($urandom_range(0, 3));
            base = 32'(i / 50) << 20;
            r = $urandom_range(0, 99);
            if (r < 20) begin
                add_item(OPC_READ, $urandom, 16'($urandom), 7'($urandom), gap, i % 150 == 149);
            end else begin
                if (r < 28) begin
                    sc = $urandom;
                end else if (r < 29) begin
                    sc = 32'hFFFFFFFF;
                end else if (r < 31) begin
                    sc = 32'h0;
                end else begin
                    sc = base + 32'($urandom_range(0, 7));
                end
                add_item(OPC_OFFER, sc, 16'($urandom), 7'($urandom), gap, i % 150 == 149);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid || want_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (faults == 0 && want_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
